[hw/rtl/jds_pkg.sv]
// ----------------------------------------------------------------------------
// jds_pkg
// Shared sizes, codes and types for the job deadline scheduler.
// ----------------------------------------------------------------------------
package jds_pkg;

  // Batch and slot limits
  localparam int MAX_JOBS    = 64;
  localparam int MAX_SLOTS   = 64;
  localparam int PROFIT_BITS = 16;

  // Derived widths
  localparam int IDX_W  = $clog2(MAX_JOBS);       // job address
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);   // job count, 0..MAX_JOBS
  localparam int SLOT_W = $clog2(MAX_SLOTS);      // slot address
  localparam int SDL_W  = $clog2(MAX_SLOTS + 1);  // saturated deadline, 0..MAX_SLOTS

  // Fixed field widths of the streams
  localparam int PROFIT_W    = 16;
  localparam int DEADLINE_W  = 7;
  localparam int JOB_INDEX_W = 6;
  localparam int STATUS_W    = 2;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 8;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_SCHED = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_OVF   = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEL,
    ST_PLACE,
    ST_EMIT_SCAN,
    ST_EMIT_READ
  } state_e;

  // One stored job
  typedef struct packed {
    logic [PROFIT_BITS-1:0] profit;
    logic [SDL_W-1:0]       deadline;
  } job_t;

endpackage

[hw/rtl/job_deadline_scheduler_unit.sv]
// Sequence: N jobs load at one item per cycle; then N + 1 scans of the job memory
//   (the last finding no job left) and N backward slot searches, each from the
//   job's deadline down to the latest free slot, if there is one.
// Emission: results leave in slot order, one per used slot; free slots are skipped.
// Throughput: one batch at a time; the job memory read port sets the ordering time.
// Reset: control, counters, slot-used and job-taken bits clear; memories are not cleared.
// ----------------------------------------------------------------------------
// job_deadline_scheduler_unit
// Greedy job sequencing with deadlines over a job memory and a slot memory.
// ----------------------------------------------------------------------------
module job_deadline_scheduler_unit import jds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [15:0] profit, [22:16] deadline, [23] zero
  input  logic                 s_axis_tlast,   // last_job
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [5:0] job_index, [7:6] zero
  output logic [STATUS_W-1:0]  m_axis_tuser,   // [1:0] status
  output logic                 m_axis_tlast    // last_of_run
);

  state_e state_q, state_d;

  // Batch bookkeeping
  logic [CNT_W-1:0]       job_cnt_q, job_cnt_d;
  logic                   ovf_q, ovf_d;
  logic [MAX_JOBS-1:0]    taken_q, taken_d;
  logic [MAX_SLOTS-1:0]   used_q, used_d;
  logic [CNT_W-1:0]       placed_q, placed_d;
  logic [CNT_W-1:0]       sent_q, sent_d;

  // Selection scan
  logic [CNT_W-1:0]       scan_q, scan_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   best_vld_q, best_vld_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [PROFIT_BITS-1:0] best_p_q, best_p_d;
  logic [SDL_W-1:0]       best_dl_q, best_dl_d;

  // Slot search and emission
  logic [SDL_W-1:0]       slot_ptr_q, slot_ptr_d;
  logic [SDL_W-1:0]       ptr_m1;
  logic [SLOT_W-1:0]      emit_q, emit_d;

  // Output register
  logic                   m_vld_q, m_vld_d;
  logic [IDX_W-1:0]       m_idx_q, m_idx_d;
  status_e                m_status_q, m_status_d;
  logic                   m_last_q, m_last_d;

  // Memories
  job_t                   job_mem [MAX_JOBS];
  job_t                   job_rd_q;
  logic                   job_we, job_re;
  logic [IDX_W-1:0]       job_raddr;
  job_t                   job_wdata;
  logic [IDX_W-1:0]       slot_mem [MAX_SLOTS];
  logic [IDX_W-1:0]       slot_rd_q;
  logic                   slot_we, slot_re;
  logic [SLOT_W-1:0]      slot_raddr;

  // Helpers
  logic                   s_acc;
  logic                   out_free;
  logic                   sel_done;
  logic                   last_item;
  logic [DEADLINE_W-1:0]  in_deadline;

  assign s_acc       = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_vld_q || m_axis_tready;
  assign sel_done    = (scan_q == job_cnt_q) && !rd_vld_q;
  assign last_item   = (sent_q == placed_q - 1'b1);
  assign ptr_m1      = slot_ptr_q - 1'b1;
  assign in_deadline = s_axis_tdata[PROFIT_W +: DEADLINE_W];

  // Job write data: profit kept to PROFIT_BITS, deadline saturated to MAX_SLOTS
  always_comb begin
    job_wdata.profit = PROFIT_BITS'(s_axis_tdata[PROFIT_W-1:0]);
    if (in_deadline > DEADLINE_W'(MAX_SLOTS)) begin
      job_wdata.deadline = SDL_W'(MAX_SLOTS);
    end else begin
      job_wdata.deadline = SDL_W'(in_deadline);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (s_acc && s_axis_tlast) state_d = ST_SEL;
      end
      ST_SEL: begin
        if (sel_done) state_d = best_vld_q ? ST_PLACE : ST_EMIT_SCAN;
      end
      ST_PLACE: begin
        if (slot_ptr_q == '0 || !used_q[ptr_m1[SLOT_W-1:0]]) state_d = ST_SEL;
      end
      ST_EMIT_SCAN: begin
        if (placed_q == '0) begin
          if (out_free) state_d = ST_LOAD;
        end else if (used_q[emit_q] && out_free) begin
          state_d = ST_EMIT_READ;
        end
      end
      ST_EMIT_READ: begin
        state_d = last_item ? ST_LOAD : ST_EMIT_SCAN;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    job_cnt_d  = job_cnt_q;
    ovf_d      = ovf_q;
    taken_d    = taken_q;
    used_d     = used_q;
    placed_d   = placed_q;
    sent_d     = sent_q;
    scan_d     = scan_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_p_d   = best_p_q;
    best_dl_d  = best_dl_q;
    slot_ptr_d = slot_ptr_q;
    emit_d     = emit_q;
    m_vld_d    = m_vld_q && !m_axis_tready;
    m_idx_d    = m_idx_q;
    m_status_d = m_status_q;
    m_last_d   = m_last_q;
    job_we     = 1'b0;
    job_re     = 1'b0;
    job_raddr  = scan_q[IDX_W-1:0];
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_raddr = emit_q;

    case (state_q)
      // store jobs until the closing item
      ST_LOAD: begin
        if (s_acc) begin
          if (job_cnt_q < CNT_W'(MAX_JOBS)) begin
            job_we    = 1'b1;
            job_cnt_d = job_cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            scan_d     = '0;
            best_vld_d = 1'b0;
          end
        end
      end

      // scan all jobs for the highest-profit untaken one, lowest index on ties
      ST_SEL: begin
        if (scan_q != job_cnt_q) begin
          job_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + 1'b1;
        end
        if (rd_vld_q && !taken_q[rd_idx_q] &&
            (!best_vld_q || job_rd_q.profit > best_p_q)) begin
          best_vld_d = 1'b1;
          best_idx_d = rd_idx_q;
          best_p_d   = job_rd_q.profit;
          best_dl_d  = job_rd_q.deadline;
        end
        if (sel_done) begin
          if (best_vld_q) begin
            taken_d[best_idx_q] = 1'b1;
            slot_ptr_d          = best_dl_q;
          end else begin
            emit_d = '0;
            sent_d = '0;
          end
        end
      end

      // walk back from the deadline to the latest free slot
      ST_PLACE: begin
        if (slot_ptr_q == '0) begin
          scan_d     = '0;
          best_vld_d = 1'b0;
        end else if (!used_q[ptr_m1[SLOT_W-1:0]]) begin
          used_d[ptr_m1[SLOT_W-1:0]] = 1'b1;
          slot_we    = 1'b1;
          placed_d   = placed_q + 1'b1;
          scan_d     = '0;
          best_vld_d = 1'b0;
        end else begin
          slot_ptr_d = ptr_m1;
        end
      end

      // find the next used slot and read its job
      ST_EMIT_SCAN: begin
        if (placed_q == '0) begin
          if (out_free) begin
            m_vld_d    = 1'b1;
            m_idx_d    = '0;
            m_status_d = STATUS_NONE;
            m_last_d   = 1'b1;
            job_cnt_d  = '0;
            ovf_d      = 1'b0;
            taken_d    = '0;
          end
        end else if (used_q[emit_q]) begin
          if (out_free) slot_re = 1'b1;
        end else begin
          emit_d = emit_q + 1'b1;
        end
      end

      // load the result register; clear the batch after the final one
      ST_EMIT_READ: begin
        m_vld_d    = 1'b1;
        m_idx_d    = slot_rd_q;
        m_status_d = ovf_q ? STATUS_OVF : STATUS_SCHED;
        m_last_d   = last_item;
        sent_d     = sent_q + 1'b1;
        emit_d     = emit_q + 1'b1;
        if (last_item) begin
          job_cnt_d = '0;
          ovf_d     = 1'b0;
          taken_d   = '0;
          used_d    = '0;
          placed_d  = '0;
        end
      end

      default: ;
    endcase
  end

  // Job memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (job_we) job_mem[job_cnt_q[IDX_W-1:0]] <= job_wdata;
    if (job_re) job_rd_q <= job_mem[job_raddr];
  end

  // Slot memory: job index held in each used slot
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[ptr_m1[SLOT_W-1:0]] <= best_idx_q;
    if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      job_cnt_q  <= '0;
      ovf_q      <= 1'b0;
      taken_q    <= '0;
      used_q     <= '0;
      placed_q   <= '0;
      sent_q     <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      emit_q     <= '0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      job_cnt_q  <= job_cnt_d;
      ovf_q      <= ovf_d;
      taken_q    <= taken_d;
      used_q     <= used_d;
      placed_q   <= placed_d;
      sent_q     <= sent_d;
      scan_q     <= scan_d;
      rd_vld_q   <= rd_vld_d;
      best_vld_q <= best_vld_d;
      emit_q     <= emit_d;
      m_vld_q    <= m_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_p_q   <= best_p_d;
    best_dl_q  <= best_dl_d;
    slot_ptr_q <= slot_ptr_d;
    m_idx_q    <= m_idx_d;
    m_status_q <= m_status_d;
    m_last_q   <= m_last_d;
  end

  // Ports
  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = M_TDATA_W'(JOB_INDEX_W'(m_idx_q));
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule

[hw/rtl/jds_checker.sv]
// ----------------------------------------------------------------------------
// jds_checker
// Port-level checks for the job deadline scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module jds_checker import jds_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]  m_axis_tuser,
  input logic                 m_axis_tlast
);

  // A stalled result keeps its item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The empty-batch result is a single closing item with index zero
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STATUS_NONE |->
      m_axis_tlast && m_axis_tdata == '0)
    else $error("nothing-scheduled result malformed");

  // Closing job stops further input until scheduling is done
  a_close_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken after closing job");

  // No new batch is taken while a run is still being emitted
  a_emit_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a run");

  // Status is always one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == STATUS_SCHED || m_axis_tuser == STATUS_NONE ||
      m_axis_tuser == STATUS_OVF)
    else $error("bad status code");

endmodule

bind job_deadline_scheduler_unit jds_checker u_jds_checker (.*);
